// ===== rtl/dri_pkg.sv =====
// Shared types and constants for the dual rail integral regulator.
// No dependencies; every rtl/ file but dri_chan_if.sv uses it by scoped name.
package dri_pkg;

  localparam int CODE_W  = 12;
  localparam int MV_W    = 14;
  localparam int MA_W    = 7;
  localparam int ACC_W   = 32;
  localparam int ADDR_W  = 8;
  localparam int DATA_W  = 14;

  // code -> mV: (code * 12500) >> 12
  localparam int MV_NUM     = 5 * 2500;
  localparam int MV_SHIFT   = 12;
  localparam int MV_PROD_W  = CODE_W + 14;
  // code -> mA: code * 2500 / (20 * 4096) == (code * 125) >> 12
  localparam int MA_NUM     = 2500 / 20;
  localparam int MA_SHIFT   = 12;
  localparam int MA_PROD_W  = CODE_W + 7;

  // drive = ((acc + 4500) * 4096) / 22500 == (s * 1024) / 5625, clamped 0..4095
  localparam int DRIVE_OFFSET = 4500;
  localparam int DRIVE_HI     = 9 * 2500;
  localparam int DRIVE_DIV    = DRIVE_HI / 4;
  localparam int DRIVE_SCALE  = 10;
  localparam int SUM_W        = 15;             // s in 1..22499 when not clamped
  localparam int RECIP_SHIFT  = 22;             // RECIP = floor(2^(22+10) / 5625)
  localparam longint RECIP    = (64'd1 << (RECIP_SHIFT + DRIVE_SCALE)) / DRIVE_DIV;
  localparam int RECIP_W      = 20;
  localparam int PROD_W       = SUM_W + RECIP_W;
  localparam int REM_W        = SUM_W + DRIVE_SCALE;
  localparam logic [CODE_W-1:0] DRIVE_MAX = '1;

  localparam logic [CODE_W-1:0] LIMIT_RESET = 12'd3276;

  // configuration register indexes
  localparam logic [ADDR_W-1:0] REG_TARGET_ONE = 8'd0;
  localparam logic [ADDR_W-1:0] REG_TARGET_TWO = 8'd1;
  localparam logic [ADDR_W-1:0] REG_LIMIT_ONE  = 8'd2;
  localparam logic [ADDR_W-1:0] REG_LIMIT_TWO  = 8'd3;

  typedef struct packed {
    logic [CODE_W-1:0] volt_code_one;
    logic [CODE_W-1:0] volt_code_two;
    logic [CODE_W-1:0] amp_code_one;
    logic [CODE_W-1:0] amp_code_two;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] drive_code_one;
    logic [CODE_W-1:0] drive_code_two;
    logic [MV_W-1:0]   measured_mv_one;
    logic [MV_W-1:0]   measured_mv_two;
    logic [MA_W-1:0]   measured_ma_one;
    logic [MA_W-1:0]   measured_ma_two;
    logic              relay_off_one;
    logic              relay_off_two;
  } out_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } cfg_word_t;

  // per-stage load strobes, each one means a valid word moves into that stage
  typedef struct packed {
    logic take1;
    logic take2;
    logic take3;
    logic take4;
  } pipe_en_t;

  typedef struct packed {
    logic [CODE_W-1:0] drive;
    logic [MV_W-1:0]   mv;
    logic [MA_W-1:0]   ma;
    logic              relay_off;
  } lane_res_t;

endpackage

// ===== rtl/dri_chan_if.sv =====
// Valid/ready channel interface, payload type set per instance.
// Used with dri_pkg word types for the input, result and configuration channels.
interface dri_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/dri_pipe_ctrl.sv =====
// Valid tracking and stall control for the four stage regulator pipeline.
// Depends on dri_pkg (pipe_en_t). Stages collapse bubbles independently.
module dri_pipe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output dri_pkg::pipe_en_t en
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic ld1, ld2, ld3, ld4;

  assign ld4 = !v4_r || out_ready;
  assign ld3 = !v3_r || ld4;
  assign ld2 = !v2_r || ld3;
  assign ld1 = !v1_r || ld2;

  assign in_ready  = ld1;
  assign out_valid = v4_r;

  always_comb begin
    en.take1 = ld1 && in_valid;
    en.take2 = ld2 && v1_r;
    en.take3 = ld3 && v2_r;
    en.take4 = ld4 && v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) v4_r <= v3_r;
    end
  end

endmodule

// ===== rtl/dri_lane.sv =====
// One rail of the regulator: unit conversion, trip latch, integrator and drive scaling.
// Depends on dri_pkg. Stages: convert, integrate, offset+reciprocal multiply, correct+clamp.
module dri_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dri_pkg::pipe_en_t             en,
  input  logic [dri_pkg::CODE_W-1:0]    volt_code,
  input  logic [dri_pkg::CODE_W-1:0]    amp_code,
  input  logic [dri_pkg::MV_W-1:0]      target_mv,
  input  logic [dri_pkg::CODE_W-1:0]    current_limit,
  output dri_pkg::lane_res_t            res
);

  // stage 1
  logic [dri_pkg::MV_PROD_W-1:0] mv_prod;
  logic [dri_pkg::MA_PROD_W-1:0] ma_prod;
  logic                          hit;
  logic                          trip_r;
  logic [dri_pkg::MV_W-1:0]      mv_s1_r;
  logic [dri_pkg::MA_W-1:0]      ma_s1_r;
  logic                          rly_s1_r;

  // stage 2
  logic [dri_pkg::ACC_W-1:0]     acc_r, acc_nxt;
  logic [dri_pkg::MV_W-1:0]      mv_s2_r;
  logic [dri_pkg::MA_W-1:0]      ma_s2_r;
  logic                          rly_s2_r;

  // stage 3
  logic signed [dri_pkg::ACC_W:0] sum;
  logic                           neg, hi;
  logic [dri_pkg::PROD_W-1:0]     prod;
  logic                           neg_s3_r, hi_s3_r;
  logic [dri_pkg::SUM_W-1:0]      sum_s3_r;
  logic [dri_pkg::PROD_W-1:0]     prod_s3_r;
  logic [dri_pkg::MV_W-1:0]       mv_s3_r;
  logic [dri_pkg::MA_W-1:0]       ma_s3_r;
  logic                           rly_s3_r;

  // stage 4
  logic [dri_pkg::CODE_W-1:0]     q0, q, drive;
  logic [dri_pkg::REM_W-1:0]      num, sub, rem;
  dri_pkg::lane_res_t             res_r;

  assign mv_prod = dri_pkg::MV_PROD_W'(volt_code) * dri_pkg::MV_PROD_W'(dri_pkg::MV_NUM);
  assign ma_prod = dri_pkg::MA_PROD_W'(amp_code) * dri_pkg::MA_PROD_W'(dri_pkg::MA_NUM);
  assign hit     = amp_code > current_limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trip_r <= 1'b0;
    end else if (en.take1 && hit) begin
      trip_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en.take1) begin
      mv_s1_r  <= mv_prod[dri_pkg::MV_SHIFT +: dri_pkg::MV_W];
      ma_s1_r  <= ma_prod[dri_pkg::MA_SHIFT +: dri_pkg::MA_W];
      rly_s1_r <= trip_r | hit;   // trip from this word shows in its own result
    end
  end

  // integrator, wraps mod 2^32
  assign acc_nxt = acc_r - dri_pkg::ACC_W'(mv_s1_r) + dri_pkg::ACC_W'(target_mv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (en.take2) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en.take2) begin
      mv_s2_r  <= mv_s1_r;
      ma_s2_r  <= ma_s1_r;
      rly_s2_r <= rly_s1_r;
    end
  end

  // s = acc + offset; s <= 0 gives 0, s >= 22500 gives full scale
  always_comb begin
    sum  = $signed({acc_r[dri_pkg::ACC_W-1], acc_r}) +
           $signed((dri_pkg::ACC_W+1)'(dri_pkg::DRIVE_OFFSET));
    neg  = sum[dri_pkg::ACC_W] || (sum == '0);
    hi   = !sum[dri_pkg::ACC_W] && (sum >= $signed((dri_pkg::ACC_W+1)'(dri_pkg::DRIVE_HI)));
    prod = dri_pkg::PROD_W'(sum[dri_pkg::SUM_W-1:0]) *
           dri_pkg::PROD_W'(dri_pkg::RECIP);
  end

  always_ff @(posedge clk) begin
    if (en.take3) begin
      neg_s3_r  <= neg;
      hi_s3_r   <= hi;
      sum_s3_r  <= sum[dri_pkg::SUM_W-1:0];
      prod_s3_r <= prod;
      mv_s3_r   <= mv_s2_r;
      ma_s3_r   <= ma_s2_r;
      rly_s3_r  <= rly_s2_r;
    end
  end

  // reciprocal estimate is exact or one low; one compare fixes it
  always_comb begin
    q0  = prod_s3_r[dri_pkg::RECIP_SHIFT +: dri_pkg::CODE_W];
    num = {sum_s3_r, {dri_pkg::DRIVE_SCALE{1'b0}}};
    sub = dri_pkg::REM_W'(q0) * dri_pkg::REM_W'(dri_pkg::DRIVE_DIV);
    rem = num - sub;
    q   = q0 + dri_pkg::CODE_W'(rem >= dri_pkg::REM_W'(dri_pkg::DRIVE_DIV));
    if (neg_s3_r) begin
      drive = '0;
    end else if (hi_s3_r) begin
      drive = dri_pkg::DRIVE_MAX;
    end else begin
      drive = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en.take4) begin
      res_r.drive     <= drive;
      res_r.mv        <= mv_s3_r;
      res_r.ma        <= ma_s3_r;
      res_r.relay_off <= rly_s3_r;
    end
  end

  assign res = res_r;

endmodule

// ===== rtl/dual_rail_integral_regulator_core.sv =====
// Top level of the dual rail integral regulator: config registers, two rail lanes,
// pipeline control and the merge into the result word.
// Depends on dri_pkg, dri_chan_if, dri_pipe_ctrl and dri_lane.
//
// Usage:
//   in_ch  : one word per control tick, two voltage codes and two current codes.
//   out_ch : one result word per input word, in order: drive codes, mV, mA, trip flags.
//   cfg_ch : register writes (index, data), always ready; write only while idle.
//            0/1 = rail targets in mV, 2/3 = current trip limits (codes).
// Throughput: one word per cycle unless stalled; each rail runs in its own lane in
//   parallel, a four stage pipe (convert, integrate, reciprocal multiply, correct).
// Stall: when out_ch.ready is low the result holds in the output register; the earlier
//   stages keep filling until the pipe is full, then in_ch.ready drops.
// Reset (rst_n low, synchronous): pipe emptied, integrators and trip latches cleared,
//   targets 0, limits 3276. Trip latches clear only by reset.
module dual_rail_integral_regulator_core (
  input  logic       clk,
  input  logic       rst_n,
  dri_chan_if.sink   in_ch,
  dri_chan_if.source out_ch,
  dri_chan_if.sink   cfg_ch
);

  logic [dri_pkg::MV_W-1:0]   target_one_r, target_two_r;
  logic [dri_pkg::CODE_W-1:0] limit_one_r, limit_two_r;
  dri_pkg::pipe_en_t          en;
  dri_pkg::lane_res_t         res_one, res_two;
  dri_pkg::in_word_t          in_word;
  dri_pkg::cfg_word_t         cfg_word;
  dri_pkg::out_word_t         out_word;

  assign in_word  = in_ch.payload;
  assign cfg_word = cfg_ch.payload;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_one_r <= '0;
      target_two_r <= '0;
      limit_one_r  <= dri_pkg::LIMIT_RESET;
      limit_two_r  <= dri_pkg::LIMIT_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_word.addr)
        dri_pkg::REG_TARGET_ONE: target_one_r <= cfg_word.data;
        dri_pkg::REG_TARGET_TWO: target_two_r <= cfg_word.data;
        dri_pkg::REG_LIMIT_ONE:  limit_one_r  <= cfg_word.data[dri_pkg::CODE_W-1:0];
        dri_pkg::REG_LIMIT_TWO:  limit_two_r  <= cfg_word.data[dri_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  dri_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .en        (en)
  );

  dri_lane u_lane_one (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .volt_code     (in_word.volt_code_one),
    .amp_code      (in_word.amp_code_one),
    .target_mv     (target_one_r),
    .current_limit (limit_one_r),
    .res           (res_one)
  );

  dri_lane u_lane_two (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .volt_code     (in_word.volt_code_two),
    .amp_code      (in_word.amp_code_two),
    .target_mv     (target_two_r),
    .current_limit (limit_two_r),
    .res           (res_two)
  );

  // merge lane results into the result word
  always_comb begin
    out_word.drive_code_one  = res_one.drive;
    out_word.drive_code_two  = res_two.drive;
    out_word.measured_mv_one = res_one.mv;
    out_word.measured_mv_two = res_two.mv;
    out_word.measured_ma_one = res_one.ma;
    out_word.measured_ma_two = res_two.ma;
    out_word.relay_off_one   = res_one.relay_off;
    out_word.relay_off_two   = res_two.relay_off;
  end

  assign out_ch.payload = out_word;

endmodule

// ===== rtl/dri_checker.sv =====
// Port-level assertions for the regulator core, attached by bind.
// Depends on dri_pkg (out_word_t) and the core's interface ports.
module dri_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input dri_pkg::out_word_t out_word
);

  logic       in_acc, out_acc;
  logic [3:0] pending_r;
  logic       seen_one_r, seen_two_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= '0;
      seen_one_r <= 1'b0;
      seen_two_r <= 1'b0;
    end else begin
      pending_r <= pending_r + 4'(in_acc) - 4'(out_acc);
      if (out_acc && out_word.relay_off_one) seen_one_r <= 1'b1;
      if (out_acc && out_word.relay_off_two) seen_two_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_word))
    else $error("result word changed while stalled");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 4'd0)
    else $error("result word without an input word");

  a_trip_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && seen_one_r |-> out_word.relay_off_one)
    else $error("rail one trip cleared");

  a_trip_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && seen_two_r |-> out_word.relay_off_two)
    else $error("rail two trip cleared");

endmodule

bind dual_rail_integral_regulator_core dri_checker u_dri_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.payload)
);

// ===== verif/dual_rail_integral_regulator_core_tb.sv =====
// Testbench for dual_rail_integral_regulator_core: directed and random words are
// checked against an in-bench model of both rail integrators and trip latches.
// Depends on rtl/dri_pkg.sv, rtl/dri_chan_if.sv and the core RTL.
module dual_rail_integral_regulator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MV_FULL_SCALE = 12500;
  localparam int unsigned MA_FULL_SCALE = 2500;
  localparam int unsigned MA_DIVISOR    = 20 * 4096;
  localparam longint      DRIVE_BIAS    = 4500;
  localparam longint      DRIVE_SPAN    = 9 * 2500;
  localparam int          CODE_MAX      = 4095;
  localparam int          MV_MAX        = 12496;
  localparam int          RESET_LIMIT   = 3276;
  localparam int          PHASES        = 6;
  localparam int          PHASE_WORDS   = 125;
  localparam int          HOLD_WORDS    = 24;
  localparam int          WRAP_WORDS    = 8;
  localparam int          MAX_REPORTS   = 40;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dri_chan_if #(.payload_t(dri_pkg::in_word_t))  in_ch  ();
  dri_chan_if #(.payload_t(dri_pkg::out_word_t)) out_ch ();
  dri_chan_if #(.payload_t(dri_pkg::cfg_word_t)) cfg_ch ();

  dual_rail_integral_regulator_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // model of the block: registers and per-rail state, index 0 = rail one
  logic [dri_pkg::MV_W-1:0]   rail_target  [2];
  logic [dri_pkg::CODE_W-1:0] rail_limit   [2];
  logic [dri_pkg::ACC_W-1:0]  rail_integ   [2];
  logic                       rail_tripped [2];
  dri_pkg::out_word_t         pending_results [$];

  int unsigned fail_count;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned reg_writes;
  bit          gaps_on;
  bit          sink_throttle;
  int unsigned sink_hold_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [dri_pkg::MV_W-1:0] code_to_millivolts(
      logic [dri_pkg::CODE_W-1:0] code);
    int unsigned prod;
    prod = code * MV_FULL_SCALE;
    return dri_pkg::MV_W'(prod >> 12);
  endfunction

  function automatic logic [dri_pkg::MA_W-1:0] code_to_milliamps(
      logic [dri_pkg::CODE_W-1:0] code);
    int unsigned prod;
    prod = code * MA_FULL_SCALE;
    return dri_pkg::MA_W'(prod / MA_DIVISOR);
  endfunction

  function automatic logic [dri_pkg::CODE_W-1:0] integ_to_drive(
      logic [dri_pkg::ACC_W-1:0] integ);
    longint quot;
    // signed division truncates toward zero, then clamp to the converter range
    quot = ((longint'($signed(integ)) + DRIVE_BIAS) * 64'sd4096) / DRIVE_SPAN;
    if (quot < 0) return '0;
    if (quot > CODE_MAX) return dri_pkg::CODE_W'(CODE_MAX);
    return dri_pkg::CODE_W'(quot);
  endfunction

  // advances both integrators and trip latches by one tick, returns the result word
  function automatic dri_pkg::out_word_t regulate_tick(dri_pkg::in_word_t w);
    logic [dri_pkg::CODE_W-1:0] volt  [2];
    logic [dri_pkg::CODE_W-1:0] amp   [2];
    logic [dri_pkg::MV_W-1:0]   mv    [2];
    logic [dri_pkg::CODE_W-1:0] drive [2];
    dri_pkg::out_word_t         res;
    volt = '{w.volt_code_one, w.volt_code_two};
    amp  = '{w.amp_code_one, w.amp_code_two};
    for (int r = 0; r < 2; r++) begin
      mv[r]         = code_to_millivolts(volt[r]);
      rail_integ[r] = rail_integ[r] - dri_pkg::ACC_W'(mv[r]) +
                      dri_pkg::ACC_W'(rail_target[r]);
      drive[r]      = integ_to_drive(rail_integ[r]);
      if (amp[r] > rail_limit[r]) rail_tripped[r] = 1'b1;
    end
    res.drive_code_one  = drive[0];
    res.drive_code_two  = drive[1];
    res.measured_mv_one = mv[0];
    res.measured_mv_two = mv[1];
    res.measured_ma_one = code_to_milliamps(amp[0]);
    res.measured_ma_two = code_to_milliamps(amp[1]);
    res.relay_off_one   = rail_tripped[0];
    res.relay_off_two   = rail_tripped[1];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    // keep the log short when something is badly broken; all are still counted
    if (fail_count <= MAX_REPORTS)
      $display("%0t ERROR %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : result_check
    dri_pkg::out_word_t got;
    dri_pkg::out_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      got = out_ch.payload;
      if (pending_results.size() == 0) begin
        report_mismatch("result word with none pending", 32'(got.drive_code_one), 0);
      end else begin
        want = pending_results.pop_front();
        check_field("drive_code_one", 32'(got.drive_code_one), 32'(want.drive_code_one));
        check_field("drive_code_two", 32'(got.drive_code_two), 32'(want.drive_code_two));
        check_field("measured_mv_one", 32'(got.measured_mv_one),
                    32'(want.measured_mv_one));
        check_field("measured_mv_two", 32'(got.measured_mv_two),
                    32'(want.measured_mv_two));
        check_field("measured_ma_one", 32'(got.measured_ma_one),
                    32'(want.measured_ma_one));
        check_field("measured_ma_two", 32'(got.measured_ma_two),
                    32'(want.measured_ma_two));
        check_field("relay_off_one", 32'(got.relay_off_one), 32'(want.relay_off_one));
        check_field("relay_off_two", 32'(got.relay_off_two), 32'(want.relay_off_two));
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: long hold requested by a test, else random stalls if sink_throttle
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_cycles != 0) begin
        sink_hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (sink_throttle && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic dri_pkg::in_word_t make_word(int unsigned v1, v2, a1, a2);
    dri_pkg::in_word_t w;
    w.volt_code_one = dri_pkg::CODE_W'(v1);
    w.volt_code_two = dri_pkg::CODE_W'(v2);
    w.amp_code_one  = dri_pkg::CODE_W'(a1);
    w.amp_code_two  = dri_pkg::CODE_W'(a2);
    return w;
  endfunction

  task automatic send_word(dri_pkg::in_word_t w);
    int unsigned idle;
    idle = gaps_on ? pick_gap() : 0;
    if (idle != 0) begin
      in_ch.valid   <= 1'b0;
      in_ch.payload <= 48'({$urandom, $urandom});
      repeat (idle) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= w;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(regulate_tick(w));
    words_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // writes all four registers, preceded by one write to an unmapped index
  task automatic set_config(logic [dri_pkg::DATA_W-1:0] target_one, target_two,
                            limit_one, limit_two);
    dri_pkg::cfg_word_t writes [5];
    drain_results();
    writes[0] = '{addr: dri_pkg::ADDR_W'($urandom_range(4, 255)),
                  data: dri_pkg::DATA_W'($urandom)};
    writes[1] = '{addr: dri_pkg::REG_TARGET_ONE, data: target_one};
    writes[2] = '{addr: dri_pkg::REG_TARGET_TWO, data: target_two};
    writes[3] = '{addr: dri_pkg::REG_LIMIT_ONE, data: limit_one};
    writes[4] = '{addr: dri_pkg::REG_LIMIT_TWO, data: limit_two};
    foreach (writes[i]) begin
      cfg_ch.valid   <= 1'b1;
      cfg_ch.payload <= writes[i];
      do @(posedge clk); while (!cfg_ch.ready);
      case (writes[i].addr)
        dri_pkg::REG_TARGET_ONE: rail_target[0] = writes[i].data;
        dri_pkg::REG_TARGET_TWO: rail_target[1] = writes[i].data;
        dri_pkg::REG_LIMIT_ONE:  rail_limit[0]  = writes[i].data[dri_pkg::CODE_W-1:0];
        dri_pkg::REG_LIMIT_TWO:  rail_limit[1]  = writes[i].data[dri_pkg::CODE_W-1:0];
        default: ;
      endcase
      reg_writes++;
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // voltage code that walks the integrator toward a random point around the
  // unclamped drive window, so the division and both clamps all get exercised
  function automatic logic [dri_pkg::CODE_W-1:0] steer_code(int r);
    int level;
    int goal;
    int delta;
    int mv;
    if ($urandom_range(0, 99) < 15) return dri_pkg::CODE_W'($urandom);
    level = int'($signed(rail_integ[r]));
    goal  = int'($urandom_range(0, 23000)) - 5000;
    delta = goal - level;
    if (delta > 6000) delta = 6000;
    if (delta < -6000) delta = -6000;
    mv = int'(rail_target[r]) - delta;
    if (mv < 0) mv = 0;
    if (mv > MV_MAX) mv = MV_MAX;
    return dri_pkg::CODE_W'((mv * 4096 + 6249) / 12500);
  endfunction

  function automatic logic [dri_pkg::CODE_W-1:0] amp_code(int r);
    int code;
    if ($urandom_range(0, 99) < 65) return dri_pkg::CODE_W'($urandom);
    code = int'(rail_limit[r]) + int'($urandom_range(0, 4)) - 2;
    if (code < 0) code = 0;
    if (code > CODE_MAX) code = CODE_MAX;
    return dri_pkg::CODE_W'(code);
  endfunction

  task automatic test_reset_defaults();
    gaps_on       = 1'b1;
    sink_throttle = 1'b1;
    // reset targets and limits; currents up to the limit must not trip
    send_word(make_word(0, 0, 0, 0));
    send_word(make_word(CODE_MAX, CODE_MAX, RESET_LIMIT, RESET_LIMIT));
    send_word(make_word(1, 2048, 1000, 2000));
    send_word(make_word(2730, 1365, 2730, 1365));
    drain_results();
  endtask

  task automatic test_drive_limits();
    // rail two target above the nominal range, rail two limit written with high bits
    set_config(14'd10000, 14'h3FFF, 14'(CODE_MAX), 14'h3FFF);
    repeat (3) send_word(make_word(0, 0, CODE_MAX, CODE_MAX));
    send_word(make_word(CODE_MAX, 1, 2048, 1));
    set_config(14'd0, 14'd0, 14'(CODE_MAX), 14'(CODE_MAX));
    // pull both integrators well below zero so the drive sits at its floor
    repeat (6) send_word(make_word(CODE_MAX, CODE_MAX, 12'h555, 12'hAAA));
    drain_results();
  endtask

  task automatic run_random_phase(bit allow_trips);
    logic [dri_pkg::DATA_W-1:0] lim [2];
    dri_pkg::in_word_t          w;
    for (int r = 0; r < 2; r++) begin
      if (!allow_trips) lim[r] = 14'(CODE_MAX);
      else if ($urandom_range(0, 4) != 0)
        lim[r] = dri_pkg::DATA_W'($urandom_range(0, CODE_MAX));
      else lim[r] = dri_pkg::DATA_W'($urandom_range(CODE_MAX + 1, 16383));
    end
    set_config(dri_pkg::DATA_W'($urandom_range(2000, 12000)),
               dri_pkg::DATA_W'($urandom_range(2000, 12000)),
               lim[0], lim[1]);
    gaps_on       = $urandom_range(0, 3) != 0;
    sink_throttle = $urandom_range(0, 3) != 0;
    repeat (PHASE_WORDS) begin
      w.volt_code_one = steer_code(0);
      w.volt_code_two = steer_code(1);
      w.amp_code_one  = amp_code(0);
      w.amp_code_two  = amp_code(1);
      send_word(w);
    end
  endtask

  task automatic test_random_regulation(bit allow_trips);
    repeat (PHASES) run_random_phase(allow_trips);
    drain_results();
  endtask

  task automatic test_backpressure();
    drain_results();
    gaps_on          = 1'b0;
    sink_throttle    = 1'b0;
    sink_hold_cycles = 60;
    // sender keeps offering while results are held, so the pipe fills and stalls
    repeat (HOLD_WORDS)
      send_word(make_word(32'(steer_code(0)), 32'(steer_code(1)), 100, 200));
    drain_results();
  endtask

  task automatic test_trip_latch();
    set_config(14'd5000, 14'd5000, 14'd100, 14'd0);
    gaps_on       = 1'b1;
    sink_throttle = 1'b1;
    send_word(make_word(1638, 1638, 100, 0));
    // a trip shows in the result of the word that caused it
    send_word(make_word(1638, 1638, 101, 0));
    send_word(make_word(1638, 1638, 0, 1));
    send_word(make_word(1638, 1638, 0, 0));
    drain_results();
  endtask

  task automatic test_accumulator_wrap();
    // rail one ramps up at the largest step, rail two ramps down at the largest step
    set_config(14'h3FFF, 14'd0, 14'(CODE_MAX), 14'(CODE_MAX));
    gaps_on       = 1'b0;
    sink_throttle = 1'b0;
    repeat (WRAP_WORDS) send_word(make_word(0, CODE_MAX, $urandom, $urandom));
    drain_results();
  endtask

  initial begin : run_tests
    in_ch.valid      <= 1'b0;
    in_ch.payload    <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.payload   <= '0;
    fail_count       = 0;
    words_sent       = 0;
    results_seen     = 0;
    reg_writes       = 0;
    gaps_on          = 1'b0;
    sink_throttle    = 1'b0;
    sink_hold_cycles = 0;
    for (int r = 0; r < 2; r++) begin
      rail_target[r]  = '0;
      rail_limit[r]   = dri_pkg::CODE_W'(RESET_LIMIT);
      rail_integ[r]   = '0;
      rail_tripped[r] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_drive_limits();
    test_random_regulation(1'b0);
    test_backpressure();
    test_trip_latch();
    test_random_regulation(1'b1);
    test_accumulator_wrap();

    drain_results();
    repeat (10) @(posedge clk);
    while (pending_results.size() != 0) begin
      report_mismatch("result word never arrived", pending_results.size(), 0);
      void'(pending_results.pop_front());
    end
    $display("Sent %0d words, checked %0d results, %0d register writes.",
             words_sent, results_seen, reg_writes);
    $display("Covered clamps, trip latching, output stall and steep integrator ramps.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("Timeout with %0d results still pending", pending_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
